@@ rtl/buddy_block_allocator_core_defines.svh @@
// Assertion macros used by the buddy allocator datapath.
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// Package with the types and constants of the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int POOL_ORDER_DEF   = 16;
	localparam int MIN_ORDER_DEF    = 6;
	localparam int HEADER_BYTES_DEF = 24;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_TOO_BIG     = 2'd1,
		ST_NO_FREE     = 2'd2,
		ST_DOUBLE_FREE = 2'd3
	} bba_status_t;

	typedef struct packed {
		logic        action;
		logic [15:0] request_bytes;
		logic [15:0] block_address;
	} bba_req_t;

	typedef struct packed {
		logic [15:0] granted_address;
		logic [4:0]  block_order;
		bba_status_t status;
	} bba_rsp_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DECODE,
		OP_SEARCH,
		OP_LOAD_HEAD,
		OP_REM_A,
		OP_REM_B,
		OP_SPLIT_DEC,
		OP_SPLIT_WB,
		OP_SPLIT_WH,
		OP_PUSH_A,
		OP_PUSH_B,
		OP_PUSH_C,
		OP_TAKE,
		OP_FREE_RD,
		OP_FREE_CHK,
		OP_MERGE_RD,
		OP_MERGE_EV,
		OP_MU1,
		OP_MU2,
		OP_FREE_DONE,
		OP_ERR,
		OP_EMIT
	} bba_op_t;

	// Which block a list operation works on.
	typedef enum logic [1:0] {
		SEL_B,
		SEL_HALF,
		SEL_BUD
	} bba_sel_t;

	typedef struct packed {
		bba_op_t     op;
		bba_sel_t    sel;
		bba_status_t err;
	} bba_cmd_t;

	typedef struct packed {
		logic act_free;
		logic too_big;
		logic bad_addr;
		logic j_over;
		logic cnt_nz;
		logic j_gt_k;
		logic cnt_le1;
		logic cnt_zero;
		logic meta_ok;
		logic j_at_top;
		logic bud_ok;
		logic out_free;
	} bba_flags_t;

endpackage
`default_nettype wire

@@ rtl/buddy_block_allocator_core.sv @@
// Top level of the binary buddy allocator: controller and datapath.
//
// The request channel (req_valid, req_stall, req_data) carries one allocate or
// free transaction. It is taken only while the sequencer is idle; req_stall is
// high from acceptance until the result has been loaded into the output register.
// The result channel (rsp_valid, rsp_stall, rsp_data) returns one transaction per
// request, in order. A result held by rsp_stall stays in the output register
// while the next request is taken; that request finishes its work and then waits.
// A request rejected at decode goes straight to the error and output states. A
// search steps up one order level at a time; each split and each merge is a
// sequence of header memory accesses, each memory having one write and one read
// port; a full split chain runs over ten levels.
// After reset the pool is one free block of the top order, slot 0 reads as that
// block until first written, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_core
	import bba_pkg::*;
#(
	parameter int POOL_ORDER   = POOL_ORDER_DEF,
	parameter int MIN_ORDER    = MIN_ORDER_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire bba_req_t req_data,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output bba_rsp_t      rsp_data
);

	bba_cmd_t   cmd;
	bba_flags_t flags;

	// Sequencer.
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// Memories, free lists and result register.
	bba_dp #(
		.POOL_ORDER   (POOL_ORDER),
		.MIN_ORDER    (MIN_ORDER),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.flags     (flags)
	);

endmodule
`default_nettype wire

@@ rtl/bba_dp.sv @@
// Datapath of the buddy allocator: header memories, free lists and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_core_defines.svh"
module bba_dp
	import bba_pkg::*;
#(
	parameter int POOL_ORDER   = POOL_ORDER_DEF,
	parameter int MIN_ORDER    = MIN_ORDER_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire bba_req_t   req_data,
	input  wire logic       rsp_stall,
	output logic            rsp_valid,
	output bba_rsp_t        rsp_data,
	input  wire bba_cmd_t   cmd,
	output bba_flags_t      flags
);

	localparam int SW   = (POOL_ORDER > MIN_ORDER) ? POOL_ORDER - MIN_ORDER : 1;
	localparam int NORD = POOL_ORDER - MIN_ORDER + 1;
	localparam int NBLK = 1 << (POOL_ORDER - MIN_ORDER);
	localparam int LW   = (NORD > 1) ? $clog2(NORD) : 1;
	localparam int OW   = $clog2(POOL_ORDER + 2);
	localparam int CW   = POOL_ORDER - MIN_ORDER + 1;
	localparam int MW   = OW + 2;
	localparam int XW   = POOL_ORDER + 17;
	localparam logic [32:0] NBLK_W = 33'(1) << (POOL_ORDER - MIN_ORDER);

	// Header memories: start, used and order in one, the list links in two more.
	logic [MW-1:0] meta_mem [NBLK];
	logic [SW-1:0] next_mem [NBLK];
	logic [SW-1:0] prev_mem [NBLK];

	bba_req_t      req_q;
	logic [OW-1:0] k_q;
	logic [OW-1:0] j_q;
	logic [SW-1:0] b_q;
	logic [SW-1:0] bud_q;
	logic [SW-1:0] t_q;
	logic [SW-1:0] head_q [NORD];
	logic [CW-1:0] cnt_q [NORD];
	bba_rsp_t      res_q;
	bba_rsp_t      rsp_q;
	logic          rsp_valid_q;
	logic          v0_q;
	logic          hit0_q;
	logic [MW-1:0] meta_rd_q;
	logic [SW-1:0] next_rd_q;
	logic [SW-1:0] prev_rd_q;

	logic          meta_we;
	logic [SW-1:0] meta_wa;
	logic [MW-1:0] meta_wd;
	logic [SW-1:0] meta_ra;
	logic          next_we;
	logic [SW-1:0] next_wa;
	logic [SW-1:0] next_wd;
	logic          prev_we;
	logic [SW-1:0] prev_wa;
	logic [SW-1:0] prev_wd;
	logic [SW-1:0] link_ra;

	logic [OW-1:0] j_off;
	logic [LW-1:0] li;
	logic [SW-1:0] half;
	logic [SW-1:0] bud_c;
	logic [SW-1:0] slot;
	logic [SW-1:0] head_c;
	logic [CW-1:0] cnt_c;
	logic [MW-1:0] meta_rd;
	logic [OW-1:0] rd_ord;
	logic [OW-1:0] ord_clamp;
	logic [16:0]   need;
	logic [OW-1:0] kc;
	logic [15:0]   off;
	logic [32:0]   slot_w;
	logic [XW-1:0] ga;
	logic [SW-1:0] lo_c;
	logic [SW-1:0] hi_c;

	// Index of the current order's list and the block offsets that follow from it.
	assign j_off  = j_q - OW'(MIN_ORDER);
	assign li     = j_off[LW-1:0];
	assign half   = SW'(1) << j_off;
	assign bud_c  = b_q ^ half;
	assign head_c = head_q[li];
	assign cnt_c  = cnt_q[li];
	assign lo_c   = (b_q < bud_q) ? b_q : bud_q;
	assign hi_c   = (b_q < bud_q) ? bud_q : b_q;

	always_comb begin
		case (cmd.sel)
			SEL_HALF: slot = b_q + half;
			SEL_BUD:  slot = bud_q;
			default:  slot = b_q;
		endcase
	end

	// Slot 0 reads as the free top-order block until it is first written.
	assign meta_rd   = hit0_q ? {1'b1, 1'b0, OW'(POOL_ORDER)} : meta_rd_q;
	assign rd_ord    = meta_rd[OW-1:0];
	assign ord_clamp = (rd_ord < OW'(MIN_ORDER) || rd_ord > OW'(POOL_ORDER)) ?
		OW'(MIN_ORDER) : rd_ord;

	// Order needed by an allocation: the smallest power of two, not below the minimum order, that holds it and its header.
	assign need = 17'(req_q.request_bytes) + 17'(HEADER_BYTES);
	always_comb begin
		kc = OW'(POOL_ORDER + 1);
		for (int i = POOL_ORDER; i >= MIN_ORDER; i--) begin
			if ((34'(1) << i) >= 34'(need)) begin
				kc = OW'(i);
			end
		end
	end

	// Block slot of a freed address.
	assign off    = req_q.block_address - 16'(HEADER_BYTES);
	assign slot_w = 33'(off) >> MIN_ORDER;
	assign ga     = (XW'(b_q) << MIN_ORDER) + XW'(HEADER_BYTES);

	// Status flags for the controller.
	always_comb begin
		flags.act_free = req_q.action;
		flags.too_big  = kc > OW'(POOL_ORDER);
		flags.bad_addr = ((33'(off) & ((33'(1) << MIN_ORDER) - 33'(1))) != 33'(0)) ||
			(slot_w >= NBLK_W);
		flags.j_over   = j_q > OW'(POOL_ORDER);
		flags.cnt_nz   = !flags.j_over && (cnt_c != '0);
		flags.j_gt_k   = j_q > k_q;
		flags.cnt_le1  = cnt_c <= CW'(1);
		flags.cnt_zero = cnt_c == '0;
		flags.meta_ok  = meta_rd[MW-1] && meta_rd[MW-2];
		flags.j_at_top = j_q >= OW'(POOL_ORDER);
		flags.bud_ok   = meta_rd[MW-1] && !meta_rd[MW-2] && (rd_ord == j_q);
		flags.out_free = !rsp_valid_q || !rsp_stall;
	end

	// Memory port selection for each operation.
	always_comb begin
		meta_we = 1'b0;
		meta_wa = b_q;
		meta_wd = {1'b1, 1'b0, j_q};
		meta_ra = b_q;
		next_we = 1'b0;
		next_wa = slot;
		next_wd = slot;
		prev_we = 1'b0;
		prev_wa = slot;
		prev_wd = slot;
		link_ra = slot;
		case (cmd.op)
			OP_REM_B: begin
				next_we = 1'b1;
				next_wa = prev_rd_q;
				next_wd = next_rd_q;
				prev_we = 1'b1;
				prev_wa = next_rd_q;
				prev_wd = prev_rd_q;
			end
			OP_PUSH_A: begin
				link_ra = head_c;
				next_we = cnt_c == '0;
				prev_we = cnt_c == '0;
			end
			OP_PUSH_B: begin
				next_we = 1'b1;
				next_wd = head_c;
				prev_we = 1'b1;
				prev_wd = prev_rd_q;
			end
			OP_PUSH_C: begin
				next_we = 1'b1;
				next_wa = t_q;
				prev_we = 1'b1;
				prev_wa = head_c;
			end
			OP_SPLIT_WB: meta_we = 1'b1;
			OP_SPLIT_WH: begin
				meta_we = 1'b1;
				meta_wa = b_q + half;
			end
			OP_TAKE: begin
				meta_we = 1'b1;
				meta_wd = {1'b1, 1'b1, k_q};
			end
			OP_FREE_CHK: begin
				meta_we = flags.meta_ok;
				meta_wd = {1'b1, 1'b0, ord_clamp};
			end
			OP_MERGE_RD: meta_ra = bud_c;
			OP_MU1: begin
				meta_we = 1'b1;
				meta_wa = hi_c;
				meta_wd = {1'b0, 1'b0, j_q};
			end
			OP_MU2: begin
				meta_we = 1'b1;
				meta_wa = lo_c;
				meta_wd = {1'b1, 1'b0, j_q + OW'(1)};
			end
			default: ;
		endcase
	end

	// Header memories with registered read data.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		meta_rd_q <= meta_mem[meta_ra];
		next_rd_q <= next_mem[link_ra];
		prev_rd_q <= prev_mem[link_ra];
	end

	// Tracks whether slot 0 still holds its reset header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q   <= 1'b0;
			hit0_q <= 1'b0;
		end else begin
			if (meta_we && meta_wa == '0) begin
				v0_q <= 1'b1;
			end
			hit0_q <= (meta_ra == '0) && !v0_q;
		end
	end

	// Free list heads and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NORD; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= (i == NORD - 1) ? CW'(1) : CW'(0);
			end
		end else begin
			case (cmd.op)
				OP_REM_A: begin
					if (cnt_c <= CW'(1)) begin
						cnt_q[li]  <= '0;
						head_q[li] <= '0;
					end
				end
				OP_REM_B: begin
					if (head_c == slot) begin
						head_q[li] <= next_rd_q;
					end
					cnt_q[li] <= cnt_c - CW'(1);
				end
				OP_PUSH_A: begin
					if (cnt_c == '0) begin
						head_q[li] <= slot;
						cnt_q[li]  <= cnt_c + CW'(1);
					end
				end
				OP_PUSH_C: begin
					head_q[li] <= slot;
					cnt_q[li]  <= cnt_c + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: req_q <= req_data;
			OP_DECODE: begin
				k_q <= kc;
				j_q <= kc;
				b_q <= slot_w[SW-1:0];
			end
			OP_SEARCH: begin
				if (!flags.j_over && cnt_c == '0) begin
					j_q <= j_q + OW'(1);
				end
			end
			OP_LOAD_HEAD: b_q <= head_c;
			OP_SPLIT_DEC: j_q <= j_q - OW'(1);
			OP_PUSH_B:    t_q <= prev_rd_q;
			OP_FREE_CHK:  j_q <= ord_clamp;
			OP_MERGE_RD:  bud_q <= bud_c;
			OP_MU2: begin
				b_q <= lo_c;
				j_q <= j_q + OW'(1);
			end
			OP_TAKE: begin
				res_q.granted_address <= ga[15:0];
				res_q.block_order     <= 5'(k_q);
				res_q.status          <= ST_OK;
			end
			OP_FREE_DONE: begin
				res_q.granted_address <= '0;
				res_q.block_order     <= 5'(j_q);
				res_q.status          <= ST_OK;
			end
			OP_ERR: begin
				res_q.granted_address <= '0;
				res_q.block_order     <= '0;
				res_q.status          <= cmd.err;
			end
			default: ;
		endcase
	end

	// Output register: loaded from the result, cleared when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`BBA_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.op == OP_EMIT, !rsp_valid_q || !rsp_stall, "result overwrote a waiting transaction")
	`BBA_ASSERT_IMP(a_unlink_count, clk, arst_n, cmd.op == OP_REM_B, cnt_c > CW'(1), "unlink from a list with one block")
	`BBA_ASSERT_IMP(a_search_order, clk, arst_n, cmd.op == OP_SEARCH, j_q >= k_q, "search below the needed order")
	`BBA_ASSERT_NEXT(a_push_seq, clk, arst_n, cmd.op == OP_PUSH_B, cmd.op == OP_PUSH_C, "list insert left unfinished")

endmodule
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
// Controller state machine of the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire bba_flags_t flags,
	output bba_cmd_t        cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_LOAD,
		S_REM_A,
		S_REM_B,
		S_SPLIT_DEC,
		S_SPLIT_WB,
		S_SPLIT_WH,
		S_PUSH_A,
		S_PUSH_B,
		S_PUSH_C,
		S_TAKE,
		S_FREE_RD,
		S_FREE_CHK,
		S_MERGE_RD,
		S_MERGE_EV,
		S_MU1,
		S_MU2,
		S_FREE_DONE,
		S_ERR,
		S_OUT
	} state_t;

	// Where a list remove or insert continues when it is done.
	typedef enum logic [2:0] {
		R_SPLIT,
		R_TAKE,
		R_PUSH_HI,
		R_PUSH_LO,
		R_MERGE,
		R_FINAL
	} ret_t;

	state_t      state_q;
	ret_t        ret_q;
	bba_status_t err_q;

	// Command decode from the current state.
	always_comb begin
		cmd.err = err_q;
		case (ret_q)
			R_PUSH_HI: cmd.sel = SEL_HALF;
			R_MERGE:   cmd.sel = SEL_BUD;
			default:   cmd.sel = SEL_B;
		endcase
		case (state_q)
			S_IDLE:      cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
			S_DECODE:    cmd.op = OP_DECODE;
			S_SEARCH:    cmd.op = OP_SEARCH;
			S_LOAD:      cmd.op = OP_LOAD_HEAD;
			S_REM_A:     cmd.op = OP_REM_A;
			S_REM_B:     cmd.op = OP_REM_B;
			S_SPLIT_DEC: cmd.op = OP_SPLIT_DEC;
			S_SPLIT_WB:  cmd.op = OP_SPLIT_WB;
			S_SPLIT_WH:  cmd.op = OP_SPLIT_WH;
			S_PUSH_A:    cmd.op = OP_PUSH_A;
			S_PUSH_B:    cmd.op = OP_PUSH_B;
			S_PUSH_C:    cmd.op = OP_PUSH_C;
			S_TAKE:      cmd.op = OP_TAKE;
			S_FREE_RD:   cmd.op = OP_FREE_RD;
			S_FREE_CHK:  cmd.op = OP_FREE_CHK;
			S_MERGE_RD:  cmd.op = OP_MERGE_RD;
			S_MERGE_EV:  cmd.op = OP_MERGE_EV;
			S_MU1:       cmd.op = OP_MU1;
			S_MU2:       cmd.op = OP_MU2;
			S_FREE_DONE: cmd.op = OP_FREE_DONE;
			S_ERR:       cmd.op = OP_ERR;
			S_OUT:       cmd.op = flags.out_free ? OP_EMIT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	assign req_stall = state_q != S_IDLE;

	// State register with the return point and error code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= R_SPLIT;
			err_q   <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (flags.act_free) begin
						if (flags.bad_addr) begin
							err_q   <= ST_DOUBLE_FREE;
							state_q <= S_ERR;
						end else begin
							state_q <= S_FREE_RD;
						end
					end else if (flags.too_big) begin
						err_q   <= ST_TOO_BIG;
						state_q <= S_ERR;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (flags.j_over) begin
						err_q   <= ST_NO_FREE;
						state_q <= S_ERR;
					end else if (flags.cnt_nz) begin
						ret_q   <= flags.j_gt_k ? R_SPLIT : R_TAKE;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_REM_A;
				S_REM_A: begin
					if (!flags.cnt_le1) begin
						state_q <= S_REM_B;
					end else begin
						case (ret_q)
							R_TAKE:  state_q <= S_TAKE;
							R_MERGE: state_q <= S_MU1;
							default: state_q <= S_SPLIT_DEC;
						endcase
					end
				end
				S_REM_B: begin
					case (ret_q)
						R_TAKE:  state_q <= S_TAKE;
						R_MERGE: state_q <= S_MU1;
						default: state_q <= S_SPLIT_DEC;
					endcase
				end
				S_SPLIT_DEC: state_q <= S_SPLIT_WB;
				S_SPLIT_WB:  state_q <= S_SPLIT_WH;
				S_SPLIT_WH: begin
					ret_q   <= R_PUSH_HI;
					state_q <= S_PUSH_A;
				end
				S_PUSH_A: begin
					if (!flags.cnt_zero) begin
						state_q <= S_PUSH_B;
					end else begin
						case (ret_q)
							R_PUSH_HI: begin
								ret_q   <= R_PUSH_LO;
								state_q <= S_PUSH_A;
							end
							R_FINAL: state_q <= S_FREE_DONE;
							default: state_q <= S_SEARCH;
						endcase
					end
				end
				S_PUSH_B: state_q <= S_PUSH_C;
				S_PUSH_C: begin
					case (ret_q)
						R_PUSH_HI: begin
							ret_q   <= R_PUSH_LO;
							state_q <= S_PUSH_A;
						end
						R_FINAL: state_q <= S_FREE_DONE;
						default: state_q <= S_SEARCH;
					endcase
				end
				S_TAKE:    state_q <= S_OUT;
				S_FREE_RD: state_q <= S_FREE_CHK;
				S_FREE_CHK: begin
					if (flags.meta_ok) begin
						state_q <= S_MERGE_RD;
					end else begin
						err_q   <= ST_DOUBLE_FREE;
						state_q <= S_ERR;
					end
				end
				S_MERGE_RD: begin
					if (flags.j_at_top) begin
						ret_q   <= R_FINAL;
						state_q <= S_PUSH_A;
					end else begin
						state_q <= S_MERGE_EV;
					end
				end
				S_MERGE_EV: begin
					if (flags.bud_ok) begin
						ret_q   <= R_MERGE;
						state_q <= S_REM_A;
					end else begin
						ret_q   <= R_FINAL;
						state_q <= S_PUSH_A;
					end
				end
				S_MU1:       state_q <= S_MU2;
				S_MU2:       state_q <= S_MERGE_RD;
				S_FREE_DONE: state_q <= S_OUT;
				S_ERR:       state_q <= S_OUT;
				S_OUT: begin
					if (flags.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
